### sv/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared widths, constants, lane codes and stage types for the
// cartesian-to-spherical converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SCALE_POS   = 48;
  localparam int VEC_W       = SCALE_POS + 3;
  localparam int ACC_W       = 32;
  localparam int ANGLE_STEPS = 24;
  localparam int RADIUS_W    = 24;
  localparam int ANGLE_W     = 16;
  localparam int SAT_POS     = 32;
  localparam int RADIX_FRAC  = 16;
  localparam int RXY_SHIFT   = 16;

  localparam int NUM_LANES  = 2;
  localparam int LANE_RAD   = 0;
  localparam int LANE_PLN   = 1;
  localparam int LANE_PHI   = 0;
  localparam int LANE_THETA = 1;

  localparam logic [ACC_W-1:0]    ACC_PI      = 32'h8000_0000;
  localparam logic [ACC_W-1:0]    ACC_HALF_PI = 32'h4000_0000;
  localparam logic [ACC_W-1:0]    ACC_ROUND   = 32'h0000_8000;
  localparam logic [ACC_W-1:0]    ACC_WRAP    = 32'hC000_0000;
  localparam logic [ANGLE_W:0]    THETA_PI    = 17'd32768;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX  = 24'hFF_FFFF;

  localparam logic [ACC_W-1:0] ATAN_TABLE [ANGLE_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] xv;
    logic signed [VEC_W-1:0] yv;
    logic [ACC_W-1:0]        acc;
  } cordic_t;

endpackage

### sv/c2s_point_if.sv
// ----------------------------------------------------------------------------
// c2s_point_if
// Valid/ready channel carrying one 3-D point item.
// ----------------------------------------------------------------------------
interface c2s_point_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic signed [COORD_WIDTH-1:0] z_coord;

  modport source (output valid, x_coord, y_coord, z_coord, input ready);
  modport sink (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

### sv/c2s_result_if.sv
// ----------------------------------------------------------------------------
// c2s_result_if
// Valid/ready channel carrying one spherical-coordinate result item.
// ----------------------------------------------------------------------------
interface c2s_result_if;
  logic                                valid;
  logic                                ready;
  logic [c2s_pkg::RADIUS_W-1:0]        radius;
  logic [c2s_pkg::ANGLE_W-1:0]         polar_angle;
  logic signed [c2s_pkg::ANGLE_W-1:0]  azimuth_angle;

  modport source (output valid, radius, polar_angle, azimuth_angle, input ready);
  modport sink (input valid, radius, polar_angle, azimuth_angle, output ready);
endinterface

### sv/cartesian_to_spherical.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Converts signed 3-D points into radius (8 fractional bits), polar angle and
// azimuth (32768 units per pi). The pipeline is a row of cells: two front-end
// stages (squares of the coordinates, then their sums), 32 root cells that
// each take one digit of the vector length and of the planar length, one
// set-up stage, one CORDIC cell per iteration for both angles, and an output
// register. One point is taken per cycle while the row is not held; the row
// holds only while the output register and the last cell are both full and
// the result is not taken. The zero vector gives radius 0 and both angles 0.
// ----------------------------------------------------------------------------
module cartesian_to_spherical #(
  parameter int ITERATIONS  = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  c2s_point_if.sink            pnt_i,
  c2s_result_if.source         res_o
);
  import c2s_pkg::*;

  localparam int SQ_W        = 2 * COORD_WIDTH;
  localparam int ROOT_SIDE_W = 3 * COORD_WIDTH + 1;
  localparam int ROT_SIDE_W  = RADIUS_W + 2;
  localparam int COORD_SHIFT = SCALE_POS - COORD_WIDTH;
  localparam int PLN_SHIFT   = RAD_W - SQ_W;

  logic                          enable;
  logic                          load;

  logic                          fr_vld;
  logic [SQ_W-1:0]               fr_planar, fr_total;
  logic signed [COORD_WIDTH-1:0] fr_x, fr_y, fr_z;
  logic [RAD_W-1:0]              total_ext;
  root_t                         rad_head, pln_head;

  logic                          root_vld  [ROOT_W+1];
  root_t [NUM_LANES-1:0]         root_vec  [ROOT_W+1];
  logic [ROOT_SIDE_W-1:0]        root_side [ROOT_W+1];

  root_t                         r_rad, r_pln;
  logic                          sat_p;
  logic signed [COORD_WIDTH-1:0] xp, yp, zp;
  logic [ROOT_W:0]               rnd;
  logic [RADIUS_W-1:0]           radius_p;
  logic signed [VEC_W-1:0]       xs, ys, zs, rxy;
  cordic_t [NUM_LANES-1:0]       prep_vec_d, prep_vec_q;
  logic [ROT_SIDE_W-1:0]         prep_side_d, prep_side_q;
  logic                          prep_vld_q;

  logic                          rot_vld  [ITERATIONS+1];
  cordic_t [NUM_LANES-1:0]       rot_vec  [ITERATIONS+1];
  logic [ROT_SIDE_W-1:0]         rot_side [ITERATIONS+1];

  logic [ACC_W-1:0]              phi_sum, tacc;
  logic [ACC_W:0]                theta_sum;
  logic [ANGLE_W:0]              theta_full;
  logic                          pz_f, zneg_f;
  logic [RADIUS_W-1:0]           radius_d, radius_q;
  logic [ANGLE_W-1:0]            polar_d, polar_q;
  logic [ANGLE_W-1:0]            azim_d, azim_q;
  logic                          out_vld_q;

  c2s_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (enable),
    .valid_i  (pnt_i.valid),
    .x_i      (pnt_i.x_coord),
    .y_i      (pnt_i.y_coord),
    .z_i      (pnt_i.z_coord),
    .valid_o  (fr_vld),
    .planar_o (fr_planar),
    .total_o  (fr_total),
    .x_o      (fr_x),
    .y_o      (fr_y),
    .z_o      (fr_z)
  );

  always_comb begin
    total_ext     = RAD_W'(fr_total);
    rad_head.rad  = RAD_W'(total_ext[SAT_POS-1:0]) << RADIX_FRAC;
    rad_head.rem  = '0;
    rad_head.root = '0;
    pln_head.rad  = RAD_W'(fr_planar) << PLN_SHIFT;
    pln_head.rem  = '0;
    pln_head.root = '0;
  end

  assign root_vld[0]           = fr_vld;
  assign root_vec[0][LANE_RAD] = rad_head;
  assign root_vec[0][LANE_PLN] = pln_head;
  assign root_side[0]          = {(|total_ext[RAD_W-1:SAT_POS]), fr_x, fr_y, fr_z};

  for (genvar s = 0; s < ROOT_W; s++) begin : g_root
    c2s_root_cell #(.SIDE_W(ROOT_SIDE_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (enable),
      .valid_i (root_vld[s]),
      .root_i  (root_vec[s]),
      .side_i  (root_side[s]),
      .valid_o (root_vld[s+1]),
      .root_o  (root_vec[s+1]),
      .side_o  (root_side[s+1])
    );
  end

  // round the length, scale and fold the start vectors
  always_comb begin
    r_rad = root_vec[ROOT_W][LANE_RAD];
    r_pln = root_vec[ROOT_W][LANE_PLN];
    sat_p = root_side[ROOT_W][3*COORD_WIDTH];
    xp    = root_side[ROOT_W][3*COORD_WIDTH-1 -: COORD_WIDTH];
    yp    = root_side[ROOT_W][2*COORD_WIDTH-1 -: COORD_WIDTH];
    zp    = root_side[ROOT_W][COORD_WIDTH-1:0];

    rnd = {1'b0, r_rad.root} + (ROOT_W+1)'(r_rad.rem > REM_W'(r_rad.root));
    if (sat_p || rnd > (ROOT_W+1)'(RADIUS_MAX)) begin
      radius_p = RADIUS_MAX;
    end else begin
      radius_p = rnd[RADIUS_W-1:0];
    end

    xs  = VEC_W'(xp) <<< COORD_SHIFT;
    ys  = VEC_W'(yp) <<< COORD_SHIFT;
    zs  = VEC_W'(zp) <<< COORD_SHIFT;
    rxy = VEC_W'(r_pln.root) << RXY_SHIFT;

    if (xp < 0) begin
      prep_vec_d[LANE_PHI].xv  = -xs;
      prep_vec_d[LANE_PHI].yv  = -ys;
      prep_vec_d[LANE_PHI].acc = ACC_PI;
    end else begin
      prep_vec_d[LANE_PHI].xv  = xs;
      prep_vec_d[LANE_PHI].yv  = ys;
      prep_vec_d[LANE_PHI].acc = '0;
    end

    if (zp < 0) begin
      prep_vec_d[LANE_THETA].xv  = rxy;
      prep_vec_d[LANE_THETA].yv  = -zs;
      prep_vec_d[LANE_THETA].acc = ACC_HALF_PI;
    end else begin
      prep_vec_d[LANE_THETA].xv  = zs;
      prep_vec_d[LANE_THETA].yv  = rxy;
      prep_vec_d[LANE_THETA].acc = '0;
    end

    prep_side_d = {radius_p, (xp == '0) && (yp == '0), zp < 0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (enable) begin
      prep_vld_q <= root_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (enable) begin
      prep_vec_q  <= prep_vec_d;
      prep_side_q <= prep_side_d;
    end
  end

  assign rot_vld[0]  = prep_vld_q;
  assign rot_vec[0]  = prep_vec_q;
  assign rot_side[0] = prep_side_q;

  for (genvar s = 0; s < ITERATIONS; s++) begin : g_rot
    c2s_cordic_cell #(.STAGE(s), .SIDE_W(ROT_SIDE_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (enable),
      .valid_i (rot_vld[s]),
      .vec_i   (rot_vec[s]),
      .side_i  (rot_side[s]),
      .valid_o (rot_vld[s+1]),
      .vec_o   (rot_vec[s+1]),
      .side_o  (rot_side[s+1])
    );
  end

  // round the angles, clamp theta, override for points on the z axis
  always_comb begin
    pz_f       = rot_side[ITERATIONS][1];
    zneg_f     = rot_side[ITERATIONS][0];
    radius_d   = rot_side[ITERATIONS][ROT_SIDE_W-1 -: RADIUS_W];
    phi_sum    = rot_vec[ITERATIONS][LANE_PHI].acc + ACC_ROUND;
    tacc       = rot_vec[ITERATIONS][LANE_THETA].acc;
    theta_sum  = {1'b0, tacc} + (ACC_W+1)'(ACC_ROUND);
    theta_full = theta_sum[ACC_W -: (ANGLE_W+1)];

    if (pz_f) begin
      azim_d  = '0;
      polar_d = zneg_f ? THETA_PI[ANGLE_W-1:0] : '0;
    end else begin
      azim_d = phi_sum[ACC_W-1 -: ANGLE_W];
      if (tacc >= ACC_WRAP) begin
        polar_d = '0;
      end else if (theta_full > THETA_PI) begin
        polar_d = THETA_PI[ANGLE_W-1:0];
      end else begin
        polar_d = theta_full[ANGLE_W-1:0];
      end
    end
  end

  assign load   = !out_vld_q || res_o.ready;
  assign enable = !rot_vld[ITERATIONS] || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= rot_vld[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && rot_vld[ITERATIONS]) begin
      radius_q <= radius_d;
      polar_q  <= polar_d;
      azim_q   <= azim_d;
    end
  end

  assign pnt_i.ready         = enable;
  assign res_o.valid         = out_vld_q;
  assign res_o.radius        = radius_q;
  assign res_o.polar_angle   = polar_q;
  assign res_o.azimuth_angle = azim_q;

endmodule

### sv/c2s_front.sv
// ----------------------------------------------------------------------------
// c2s_front
// Two-stage front end: squares of the coordinates, then the planar and
// total sums of squares.
// ----------------------------------------------------------------------------
module c2s_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [COORD_WIDTH-1:0]   x_i,
  input  logic signed [COORD_WIDTH-1:0]   y_i,
  input  logic signed [COORD_WIDTH-1:0]   z_i,
  output logic                            valid_o,
  output logic [2*COORD_WIDTH-1:0]        planar_o,
  output logic [2*COORD_WIDTH-1:0]        total_o,
  output logic signed [COORD_WIDTH-1:0]   x_o,
  output logic signed [COORD_WIDTH-1:0]   y_o,
  output logic signed [COORD_WIDTH-1:0]   z_o
);
  localparam int SQ_W = 2 * COORD_WIDTH;

  logic [COORD_WIDTH-1:0]        ax, ay, az;
  logic [SQ_W-1:0]               sqx_d, sqy_d, sqz_d;
  logic [SQ_W-1:0]               sqx_q, sqy_q, sqz_q;
  logic [SQ_W-1:0]               planar_d, total_d;
  logic [SQ_W-1:0]               planar_q, total_q;
  logic signed [COORD_WIDTH-1:0] x1_q, y1_q, z1_q;
  logic signed [COORD_WIDTH-1:0] x2_q, y2_q, z2_q;
  logic                          v1_q, v2_q;

  always_comb begin
    ax       = x_i[COORD_WIDTH-1] ? COORD_WIDTH'(-x_i) : COORD_WIDTH'(x_i);
    ay       = y_i[COORD_WIDTH-1] ? COORD_WIDTH'(-y_i) : COORD_WIDTH'(y_i);
    az       = z_i[COORD_WIDTH-1] ? COORD_WIDTH'(-z_i) : COORD_WIDTH'(z_i);
    sqx_d    = SQ_W'(ax) * SQ_W'(ax);
    sqy_d    = SQ_W'(ay) * SQ_W'(ay);
    sqz_d    = SQ_W'(az) * SQ_W'(az);
    planar_d = sqx_q + sqy_q;
    total_d  = sqx_q + sqy_q + sqz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q    <= sqx_d;
      sqy_q    <= sqy_d;
      sqz_q    <= sqz_d;
      x1_q     <= x_i;
      y1_q     <= y_i;
      z1_q     <= z_i;
      planar_q <= planar_d;
      total_q  <= total_d;
      x2_q     <= x1_q;
      y2_q     <= y1_q;
      z2_q     <= z1_q;
    end
  end

  assign valid_o  = v2_q;
  assign planar_o = planar_q;
  assign total_o  = total_q;
  assign x_o      = x2_q;
  assign y_o      = y2_q;
  assign z_o      = z2_q;

endmodule

### sv/c2s_root_cell.sv
// ----------------------------------------------------------------------------
// c2s_root_cell
// One digit step of two restoring square roots side by side: takes two
// radicand bits, yields one root bit per lane.
// ----------------------------------------------------------------------------
module c2s_root_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  c2s_pkg::root_t [c2s_pkg::NUM_LANES-1:0]    root_i,
  input  logic [SIDE_W-1:0]                          side_i,
  output logic                                       valid_o,
  output c2s_pkg::root_t [c2s_pkg::NUM_LANES-1:0]    root_o,
  output logic [SIDE_W-1:0]                          side_o
);
  import c2s_pkg::*;

  logic                        valid_q;
  root_t [NUM_LANES-1:0]       root_d, root_q;
  logic [SIDE_W-1:0]           side_q;
  logic [REM_W+1:0]            cur   [NUM_LANES];
  logic [REM_W+1:0]            trial [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      cur[l]         = {root_i[l].rem, root_i[l].rad[RAD_W-1 -: 2]};
      trial[l]       = {2'b00, root_i[l].root, 2'b01};
      root_d[l].rad  = root_i[l].rad << 2;
      if (cur[l] >= trial[l]) begin
        root_d[l].rem  = REM_W'(cur[l] - trial[l]);
        root_d[l].root = {root_i[l].root[ROOT_W-2:0], 1'b1};
      end else begin
        root_d[l].rem  = cur[l][REM_W-1:0];
        root_d[l].root = {root_i[l].root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

### sv/c2s_cordic_cell.sv
// ----------------------------------------------------------------------------
// c2s_cordic_cell
// One vectoring micro-rotation for the azimuth and polar lanes at a fixed
// stage index.
// ----------------------------------------------------------------------------
module c2s_cordic_cell #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  c2s_pkg::cordic_t [c2s_pkg::NUM_LANES-1:0]  vec_i,
  input  logic [SIDE_W-1:0]                          side_i,
  output logic                                       valid_o,
  output c2s_pkg::cordic_t [c2s_pkg::NUM_LANES-1:0]  vec_o,
  output logic [SIDE_W-1:0]                          side_o
);
  import c2s_pkg::*;

  logic                    valid_q;
  cordic_t [NUM_LANES-1:0] vec_d, vec_q;
  logic [SIDE_W-1:0]       side_q;
  logic signed [VEC_W-1:0] dx [NUM_LANES];
  logic signed [VEC_W-1:0] dy [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      dx[l] = $signed(vec_i[l].yv) >>> STAGE;
      dy[l] = $signed(vec_i[l].xv) >>> STAGE;
      if ($signed(vec_i[l].yv) > 0) begin
        vec_d[l].xv  = vec_i[l].xv + dx[l];
        vec_d[l].yv  = vec_i[l].yv - dy[l];
        vec_d[l].acc = vec_i[l].acc + ATAN_TABLE[STAGE];
      end else begin
        vec_d[l].xv  = vec_i[l].xv - dx[l];
        vec_d[l].yv  = vec_i[l].yv + dy[l];
        vec_d[l].acc = vec_i[l].acc - ATAN_TABLE[STAGE];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q  <= vec_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

### verif/spherical_result_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spherical_result_check
// Watches the point and result channels of the converter. Each accepted point
// is turned into its expected radius, polar angle and azimuth by a bit-exact
// integer square root and two CORDIC vectoring passes. Each accepted result
// is compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module spherical_result_check #(
  parameter int ITERATIONS  = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 pnt_valid_i,
  input  logic                                 pnt_ready_i,
  input  logic signed [COORD_WIDTH-1:0]        x_coord_i,
  input  logic signed [COORD_WIDTH-1:0]        y_coord_i,
  input  logic signed [COORD_WIDTH-1:0]        z_coord_i,
  input  logic                                 res_valid_i,
  input  logic                                 res_ready_i,
  input  logic [c2s_pkg::RADIUS_W-1:0]         radius_i,
  input  logic [c2s_pkg::ANGLE_W-1:0]          polar_angle_i,
  input  logic signed [c2s_pkg::ANGLE_W-1:0]   azimuth_angle_i,
  output int                                   pending_o,
  output int                                   mismatch_cnt_o,
  output int                                   checked_cnt_o
);
  import c2s_pkg::*;

  localparam int TABLE_LEN = 24;

  localparam logic [31:0] ATAN_STEP [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic [RADIUS_W-1:0]       radius;
    logic [ANGLE_W-1:0]        polar;
    logic signed [ANGLE_W-1:0] azimuth;
  } sph_t;

  sph_t expected_sph [$];
  sph_t want;
  int   mismatches;
  int   checked;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v   -= res + probe;
        res  = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] cordic_angle(longint xv, longint yv, logic [31:0] acc);
    longint dx;
    longint dy;
    for (int i = 0; i < ITERATIONS && i < TABLE_LEN; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv  += dx;
        yv  -= dy;
        acc += ATAN_STEP[i];
      end else begin
        xv  -= dx;
        yv  += dy;
        acc -= ATAN_STEP[i];
      end
    end
    return acc;
  endfunction

  function automatic sph_t to_spherical(logic signed [COORD_WIDTH-1:0] xc,
                                        logic signed [COORD_WIDTH-1:0] yc,
                                        logic signed [COORD_WIDTH-1:0] zc);
    longint          x, y, z, xs, ys, rxy, zs, t;
    longint unsigned ax, ay, az, planar, total, v, q;
    logic [31:0]     acc, tacc, rnd;
    sph_t            r;
    x      = xc;
    y      = yc;
    z      = zc;
    ax     = (x < 0) ? -x : x;
    ay     = (y < 0) ? -y : y;
    az     = (z < 0) ? -z : z;
    planar = ax * ax + ay * ay;
    total  = planar + az * az;

    if (total >= (64'd1 << 32)) begin
      r.radius = '1;
    end else begin
      v = total << 16;
      q = root_floor(v);
      if (v - q * q > q) q++;
      r.radius = (q > 64'hFF_FFFF) ? '1 : RADIUS_W'(q);
    end

    if (planar == 0) begin
      r.azimuth = '0;
      r.polar   = (z < 0) ? 16'd32768 : 16'd0;
    end else begin
      xs  = x <<< (48 - COORD_WIDTH);
      ys  = y <<< (48 - COORD_WIDTH);
      acc = '0;
      if (x < 0) begin
        xs  = -xs;
        ys  = -ys;
        acc = 32'h8000_0000;
      end
      acc       = cordic_angle(xs, ys, acc);
      rnd       = acc + 32'h0000_8000;
      r.azimuth = rnd[31:16];

      rxy = longint'(root_floor(planar << (2 * (32 - COORD_WIDTH)))) * 65536;
      zs  = (z <<< (32 - COORD_WIDTH)) * 65536;
      if (z < 0) tacc = cordic_angle(rxy, -zs, 32'h4000_0000);
      else tacc = cordic_angle(zs, rxy, 32'h0);
      t = {32'd0, tacc};
      t = (t + 32768) >>> 16;
      if (tacc >= 32'hC000_0000) t = 0;
      if (t > 32768) t = 32768;
      r.polar = ANGLE_W'(t);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_sph.delete();
      mismatches = 0;
      checked    = 0;
      pending_o      <= 0;
      mismatch_cnt_o <= 0;
      checked_cnt_o  <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_sph.size() == 0) begin
          $error("result item with no point pending: radius %0d polar %0d azimuth %0d",
                 radius_i, polar_angle_i, azimuth_angle_i);
          mismatches++;
        end else begin
          want = expected_sph.pop_front();
          if (radius_i !== want.radius) begin
            $error("radius mismatch: expected %0d, got %0d", want.radius, radius_i);
            mismatches++;
          end
          if (polar_angle_i !== want.polar) begin
            $error("polar_angle mismatch: expected %0d, got %0d", want.polar, polar_angle_i);
            mismatches++;
          end
          if (azimuth_angle_i !== want.azimuth) begin
            $error("azimuth_angle mismatch: expected %0d, got %0d",
                   want.azimuth, azimuth_angle_i);
            mismatches++;
          end
          checked++;
        end
      end
      if (pnt_valid_i && pnt_ready_i) begin
        expected_sph.push_back(to_spherical(x_coord_i, y_coord_i, z_coord_i));
      end
      pending_o      <= expected_sph.size();
      mismatch_cnt_o <= mismatches;
      checked_cnt_o  <= checked;
    end
  end

endmodule

### verif/cartesian_to_spherical_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cartesian_to_spherical_tb
// Streams corner-case and random 3-D points through the converter with random
// gaps on both channels, a long output stall that backs up the pipeline, a
// full drain mid-run and a stretch at full rate. Checking is done by
// spherical_result_check beside the block.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_tb;
  import c2s_pkg::*;

  localparam int ITERATIONS    = 16;
  localparam int COORD_WIDTH   = 16;
  localparam int IDLE_PCT      = 21;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_CYCLES  = 36 + ITERATIONS + 16;
  localparam int NUM_CORNERS   = 24;

  localparam logic signed [COORD_WIDTH-1:0] CORNER_PTS [NUM_CORNERS][3] = '{
    '{0, 0, 0},
    '{32767, 32767, 32767},
    '{-32768, -32768, -32768},
    '{-32768, 0, 0},
    '{32767, 0, 0},
    '{0, 32767, 0},
    '{0, -32768, 0},
    '{0, 0, 32767},
    '{0, 0, -32768},
    '{0, 0, 1},
    '{0, 0, -1},
    '{1, 0, 0},
    '{-1, 0, 0},
    '{0, 1, 0},
    '{1, 1, 1},
    '{-1, -1, -1},
    '{-32768, 32767, 0},
    '{-1, 0, 5},
    '{32767, -32768, -32768},
    '{-32768, -1, 0},
    '{-32768, 1, 0},
    '{3, 4, 0},
    '{1, 0, 32767},
    '{1, 0, -32767}
  };

  localparam logic signed [COORD_WIDTH-1:0] EDGE_VALS [6] = '{
    -32768, -32767, -1, 0, 1, 32767
  };

  logic clk_i;
  logic rst_ni;

  c2s_point_if #(.COORD_WIDTH(COORD_WIDTH)) pnt_if ();
  c2s_result_if                             res_if ();

  int src_idle_pct;
  int sink_idle_pct;
  int hold_starts;
  int pending;
  int mismatch_cnt;
  int checked_cnt;
  int corners_sent;
  int random_sent;

  cartesian_to_spherical #(
    .ITERATIONS (ITERATIONS),
    .COORD_WIDTH(COORD_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pnt_i (pnt_if),
    .res_o (res_if)
  );

  spherical_result_check #(
    .ITERATIONS (ITERATIONS),
    .COORD_WIDTH(COORD_WIDTH)
  ) sph_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pnt_valid_i    (pnt_if.valid),
    .pnt_ready_i    (pnt_if.ready),
    .x_coord_i      (pnt_if.x_coord),
    .y_coord_i      (pnt_if.y_coord),
    .z_coord_i      (pnt_if.z_coord),
    .res_valid_i    (res_if.valid),
    .res_ready_i    (res_if.ready),
    .radius_i       (res_if.radius),
    .polar_angle_i  (res_if.polar_angle),
    .azimuth_angle_i(res_if.azimuth_angle),
    .pending_o      (pending),
    .mismatch_cnt_o (mismatch_cnt),
    .checked_cnt_o  (checked_cnt)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
                            input logic signed [COORD_WIDTH-1:0] y,
                            input logic signed [COORD_WIDTH-1:0] z);
    while ($urandom_range(99) < src_idle_pct) begin
      pnt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pnt_if.valid   <= 1'b1;
    pnt_if.x_coord <= x;
    pnt_if.y_coord <= y;
    pnt_if.z_coord <= z;
    do @(posedge clk_i); while (!pnt_if.ready);
  endtask

  task automatic send_random_points(input int count);
    int unsigned                   shape;
    logic signed [COORD_WIDTH-1:0] c [3];
    repeat (count) begin
      shape = $urandom_range(99);
      for (int k = 0; k < 3; k++) begin
        if (shape < 50) c[k] = COORD_WIDTH'($urandom());
        else if (shape < 70) c[k] = COORD_WIDTH'($signed($urandom_range(64)) - 32);
        else if (shape < 85) c[k] = EDGE_VALS[$urandom_range(5)];
        else c[k] = ($urandom_range(1) == 0) ? '0 : COORD_WIDTH'($urandom());
      end
      send_point(c[0], c[1], c[2]);
      random_sent++;
    end
  endtask

  task automatic wait_drained();
    pnt_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_seen != hold_starts) begin
        hold_seen    = hold_starts;
        hold_left    = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    pnt_if.valid   <= 1'b0;
    pnt_if.x_coord <= '0;
    pnt_if.y_coord <= '0;
    pnt_if.z_coord <= '0;
    rst_ni         <= 1'b0;
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
    hold_starts   = 0;
    corners_sent  = 0;
    random_sent   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < NUM_CORNERS; n++) begin
      send_point(CORNER_PTS[n][0], CORNER_PTS[n][1], CORNER_PTS[n][2]);
      corners_sent++;
    end

    send_random_points(250);

    // stall the output long enough to back up the whole pipeline
    hold_starts = hold_starts + 1;
    send_random_points(100);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_random_points(150);
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;

    send_random_points(200);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d corner points and %0d random points, including a %0d-cycle output stall",
             corners_sent, random_sent, HOLD_CYCLES);
    $display("Checked %0d results, %0d field mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule

### cartesian_to_spherical.f
sv/c2s_pkg.sv
sv/c2s_point_if.sv
sv/c2s_result_if.sv
sv/c2s_front.sv
sv/c2s_root_cell.sv
sv/c2s_cordic_cell.sv
sv/cartesian_to_spherical.sv
verif/spherical_result_check.sv
verif/cartesian_to_spherical_tb.sv
